FILE: rtl/core/gopd_pkg.sv
// Shared types and constants for the glyph outline point decoder.
// Used by gopd_ctrl, gopd_dp and the top level; depends on nothing.
package gopd_pkg;

    localparam int MaxPoints   = 256;
    localparam int MaxContours = 32;
    localparam int PtW  = $clog2(MaxPoints);
    localparam int CtW  = $clog2(MaxContours);

    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_FETCH   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [2:0] ST_ACCEPT = 3'd0;
    localparam logic [2:0] ST_DONE   = 3'd1;
    localparam logic [2:0] ST_POINT  = 3'd2;
    localparam logic [2:0] ST_UNSUP  = 3'd3;
    localparam logic [2:0] ST_OVF    = 3'd4;
    localparam logic [2:0] ST_MISUSE = 3'd5;

    typedef enum logic [3:0] {
        PH_HDR, PH_ENDS, PH_INSLEN, PH_INSTR, PH_FLAGS, PH_FLAGREP,
        PH_X, PH_Y, PH_DONE, PH_ERR_UNSUP, PH_ERR_OVF
    } phase_t;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_BYTE, CMD_XY_LATCH, CMD_XY_PROC, CMD_REP_STEP, CMD_FLAG_END,
        CMD_SET_ADV, CMD_SET_CHK, CMD_FETCH_OUT, CMD_RESTART, CMD_MISUSE, CMD_EMIT
    } cmd_t;

    typedef struct packed {
        phase_t phase;
        logic   at_end;
        logic   need_settle;
        logic   rep_go;
        logic   fetch_ok;
    } dp_stat_t;

endpackage

FILE: rtl/core/gopd_ctrl.sv
// Sequencer of the glyph outline point decoder: takes words, steps the
// datapath through each one and hands the result to the output register.
// Depends on gopd_pkg.
module gopd_ctrl
    import gopd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic [1:0] op,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_XY_PROC, S_REP, S_SET_RD, S_SET_CHK, S_FETCH_OUT, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = CMD_NONE;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    priority if (op == OP_RESTART)
                    begin
                        cmd        = CMD_RESTART;
                        state_next = S_OUT;
                    end
                    else if (op == OP_FETCH)
                    begin
                        if (stat.fetch_ok)
                        begin
                            state_next = S_FETCH_OUT;
                        end
                        else
                        begin
                            cmd        = CMD_MISUSE;
                            state_next = S_OUT;
                        end
                    end
                    else if (op == OP_BYTE)
                    begin
                        if (stat.phase == PH_X || stat.phase == PH_Y)
                        begin
                            cmd        = CMD_XY_LATCH;
                            state_next = S_XY_PROC;
                        end
                        else
                        begin
                            cmd        = CMD_BYTE;
                            state_next = (stat.phase == PH_FLAGREP) ? S_REP : S_SET_RD;
                        end
                    end
                    else
                    begin
                        cmd        = CMD_MISUSE;
                        state_next = S_OUT;
                    end
                end
            end
            S_XY_PROC:
            begin
                cmd        = CMD_XY_PROC;
                state_next = S_SET_RD;
            end
            S_REP:
            begin
                if (stat.rep_go)
                begin
                    cmd = CMD_REP_STEP;
                end
                else
                begin
                    cmd        = CMD_FLAG_END;
                    state_next = S_SET_RD;
                end
            end
            S_SET_RD:
            begin
                // Flag memory output is registered, so it is valid in the cycle after the cursor settles.
                priority if (!stat.need_settle)
                begin
                    state_next = S_OUT;
                end
                else if (stat.at_end)
                begin
                    cmd = CMD_SET_ADV;
                end
                else
                begin
                    state_next = S_SET_CHK;
                end
            end
            S_SET_CHK:
            begin
                cmd        = CMD_SET_CHK;
                state_next = S_SET_RD;
            end
            S_FETCH_OUT:
            begin
                cmd        = CMD_FETCH_OUT;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd        = CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd == CMD_EMIT)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/core/gopd_dp.sv
// Datapath of the glyph outline point decoder: record parsing registers,
// flag, coordinate and end-index memories, and the output register.
// Depends on gopd_pkg.
module gopd_dp
    import gopd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    input  logic [7:0]        data_byte,
    output dp_stat_t          stat,
    output logic [2:0]        status,
    output logic signed [15:0] point_x,
    output logic signed [15:0] point_y,
    output logic              on_curve,
    output logic              contour_end,
    output logic              last_point,
    output logic [7:0]        point_index
);

    phase_t        phase_reg, phase_next;
    logic [15:0]   pbc_reg, pbc_next;
    logic [CtW:0]  cc_reg, cc_next;
    logic [PtW:0]  pc_reg, pc_next;
    logic [PtW:0]  cur_reg, cur_next;
    logic [7:0]    rep_reg, rep_next;
    logic [15:0]   run_reg, run_next;
    logic [7:0]    word_reg, word_next;
    logic [CtW:0]  fc_reg, fc_next;
    logic          settle_reg, settle_next;
    logic [2:0]    res_reg, res_next;
    logic [5:0]    lflag_reg, lflag_next;
    logic [7:0]    byte_reg;
    logic          ce_reg, ce_next;
    logic          last_reg, last_next;
    logic [15:0]   px_reg, py_reg;
    logic          on_reg;
    logic [7:0]    idx_reg;

    logic [5:0]    flag_mem [MaxPoints];
    logic [15:0]   x_mem [MaxPoints];
    logic [15:0]   y_mem [MaxPoints];
    logic [PtW-1:0] end_mem [MaxContours];
    logic [5:0]    flag_q;
    logic [15:0]   x_q, y_q;
    logic [PtW-1:0] end_q;

    logic          flag_we, coord_we, end_we;
    logic [5:0]    flag_wd;
    logic [PtW-1:0] end_wd;
    logic [CtW-1:0] end_wa;

    logic [15:0]   n_word;
    logic [15:0]   xy_word;
    logic [15:0]   pbc_inc;
    logic [PtW:0]  cur_inc;
    logic          is_y, f_short, f_same;

    assign n_word  = {word_reg, data_byte};
    assign xy_word = {word_reg, byte_reg};
    assign pbc_inc = pbc_reg + 16'd1;
    assign cur_inc = cur_reg + 1'b1;
    assign is_y    = (phase_reg == PH_Y);
    assign f_short = is_y ? flag_q[2] : flag_q[1];
    assign f_same  = is_y ? flag_q[5] : flag_q[4];

    assign stat.phase       = phase_reg;
    assign stat.at_end      = (cur_reg >= pc_reg);
    assign stat.need_settle = settle_reg;
    assign stat.rep_go      = (rep_reg != 8'd0) && (cur_reg < pc_reg);
    assign stat.fetch_ok    = (phase_reg == PH_DONE) && (cur_reg < pc_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        pbc_next    = pbc_reg;
        cc_next     = cc_reg;
        pc_next     = pc_reg;
        cur_next    = cur_reg;
        rep_next    = rep_reg;
        run_next    = run_reg;
        word_next   = word_reg;
        fc_next     = fc_reg;
        settle_next = settle_reg;
        res_next    = res_reg;
        lflag_next  = lflag_reg;
        ce_next     = ce_reg;
        last_next   = last_reg;
        flag_we     = 1'b0;
        flag_wd     = data_byte[5:0];
        coord_we    = 1'b0;
        end_we      = 1'b0;
        end_wd      = n_word[PtW-1:0];
        end_wa      = pbc_reg[CtW:1];

        unique case (cmd)
            CMD_BYTE:
            begin
                res_next = ST_ACCEPT;
                unique case (phase_reg)
                    PH_HDR:
                    begin
                        priority if (pbc_reg == 16'd1 && (n_word == 16'd0 || n_word[15]))
                        begin
                            phase_next = PH_ERR_UNSUP;
                            res_next   = ST_UNSUP;
                        end
                        else if (pbc_reg == 16'd1 && n_word > 16'(MaxContours))
                        begin
                            phase_next = PH_ERR_OVF;
                            res_next   = ST_OVF;
                        end
                        else
                        begin
                            if (pbc_reg == 16'd0)
                            begin
                                word_next = data_byte;
                            end
                            if (pbc_reg == 16'd1)
                            begin
                                cc_next = n_word[CtW:0];
                            end
                            if (pbc_inc >= 16'd10)
                            begin
                                phase_next = PH_ENDS;
                                pbc_next   = 16'd0;
                            end
                            else
                            begin
                                pbc_next = pbc_inc;
                            end
                        end
                    end
                    PH_ENDS:
                    begin
                        if (pbc_reg[0] && n_word >= 16'(MaxPoints))
                        begin
                            phase_next = PH_ERR_OVF;
                            res_next   = ST_OVF;
                        end
                        else
                        begin
                            if (!pbc_reg[0])
                            begin
                                word_next = data_byte;
                            end
                            else
                            begin
                                end_we  = 1'b1;
                                pc_next = {1'b0, n_word[PtW-1:0]} + 1'b1;
                            end
                            if (pbc_inc >= {{(14-CtW){1'b0}}, cc_reg, 1'b0})
                            begin
                                phase_next = PH_INSLEN;
                                pbc_next   = 16'd0;
                            end
                            else
                            begin
                                pbc_next = pbc_inc;
                            end
                        end
                    end
                    PH_INSLEN:
                    begin
                        if (pbc_reg == 16'd0)
                        begin
                            word_next = data_byte;
                            pbc_next  = 16'd1;
                        end
                        else
                        begin
                            pbc_next   = n_word;
                            phase_next = (n_word != 16'd0) ? PH_INSTR : PH_FLAGS;
                            cur_next   = '0;
                        end
                    end
                    PH_INSTR:
                    begin
                        pbc_next = pbc_reg - 16'd1;
                        if (pbc_reg == 16'd1)
                        begin
                            phase_next = PH_FLAGS;
                        end
                    end
                    PH_FLAGS:
                    begin
                        flag_we    = 1'b1;
                        lflag_next = data_byte[5:0];
                        cur_next   = cur_inc;
                        if (data_byte[3])
                        begin
                            phase_next = PH_FLAGREP;
                        end
                        else if (cur_inc >= pc_reg)
                        begin
                            phase_next  = PH_X;
                            cur_next    = '0;
                            run_next    = 16'd0;
                            pbc_next    = 16'd0;
                            settle_next = 1'b1;
                        end
                    end
                    PH_FLAGREP:
                    begin
                        rep_next = data_byte;
                    end
                    PH_ERR_UNSUP:
                    begin
                        res_next = ST_UNSUP;
                    end
                    PH_ERR_OVF:
                    begin
                        res_next = ST_OVF;
                    end
                    default:
                    begin
                        res_next = ST_MISUSE;
                    end
                endcase
            end
            CMD_REP_STEP:
            begin
                flag_we  = 1'b1;
                flag_wd  = lflag_reg;
                cur_next = cur_inc;
                rep_next = rep_reg - 8'd1;
            end
            CMD_FLAG_END:
            begin
                rep_next   = 8'd0;
                phase_next = PH_FLAGS;
                if (cur_reg >= pc_reg)
                begin
                    phase_next  = PH_X;
                    cur_next    = '0;
                    run_next    = 16'd0;
                    pbc_next    = 16'd0;
                    settle_next = 1'b1;
                end
            end
            CMD_XY_LATCH:
            begin
                res_next = ST_ACCEPT;
            end
            CMD_XY_PROC:
            begin
                priority if (f_short)
                begin
                    run_next    = f_same ? run_reg + {8'd0, byte_reg}
                                         : run_reg - {8'd0, byte_reg};
                    coord_we    = 1'b1;
                    cur_next    = cur_inc;
                    settle_next = 1'b1;
                end
                else if (pbc_reg == 16'd0)
                begin
                    word_next   = byte_reg;
                    pbc_next    = 16'd1;
                    settle_next = 1'b0;
                end
                else
                begin
                    run_next    = run_reg + xy_word;
                    pbc_next    = 16'd0;
                    coord_we    = 1'b1;
                    cur_next    = cur_inc;
                    settle_next = 1'b1;
                end
            end
            CMD_SET_ADV:
            begin
                cur_next = '0;
                run_next = 16'd0;
                pbc_next = 16'd0;
                if (is_y)
                begin
                    phase_next  = PH_DONE;
                    fc_next     = '0;
                    settle_next = 1'b0;
                    res_next    = ST_DONE;
                end
                else
                begin
                    phase_next = PH_Y;
                end
            end
            CMD_SET_CHK:
            begin
                // A point whose coordinate repeats the previous one takes no bytes.
                if (!f_short && f_same)
                begin
                    coord_we = 1'b1;
                    cur_next = cur_inc;
                end
                else
                begin
                    settle_next = 1'b0;
                end
            end
            CMD_FETCH_OUT:
            begin
                ce_next   = (fc_reg < cc_reg) && (end_q == cur_reg[PtW-1:0]);
                last_next = (cur_inc == pc_reg);
                if ((fc_reg < cc_reg) && (end_q == cur_reg[PtW-1:0]))
                begin
                    fc_next = fc_reg + 1'b1;
                end
                cur_next = cur_inc;
                res_next = ST_POINT;
            end
            CMD_RESTART:
            begin
                phase_next  = PH_HDR;
                pbc_next    = 16'd0;
                cc_next     = '0;
                pc_next     = '0;
                cur_next    = '0;
                rep_next    = 8'd0;
                run_next    = 16'd0;
                word_next   = 8'd0;
                fc_next     = '0;
                settle_next = 1'b0;
                res_next    = ST_ACCEPT;
            end
            CMD_MISUSE:
            begin
                res_next = ST_MISUSE;
            end
            CMD_NONE, CMD_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR;
            pbc_reg    <= 16'd0;
            cc_reg     <= '0;
            pc_reg     <= '0;
            cur_reg    <= '0;
            rep_reg    <= 8'd0;
            run_reg    <= 16'd0;
            word_reg   <= 8'd0;
            fc_reg     <= '0;
            settle_reg <= 1'b0;
            res_reg    <= ST_ACCEPT;
        end
        else
        begin
            phase_reg  <= phase_next;
            pbc_reg    <= pbc_next;
            cc_reg     <= cc_next;
            pc_reg     <= pc_next;
            cur_reg    <= cur_next;
            rep_reg    <= rep_next;
            run_reg    <= run_next;
            word_reg   <= word_next;
            fc_reg     <= fc_next;
            settle_reg <= settle_next;
            res_reg    <= res_next;
        end
    end

    // Payload registers without reset. The fetched point is captured while the
    // memory data still belongs to it, since the cursor moves on right after.
    always_ff @(posedge clk)
    begin
        lflag_reg <= lflag_next;
        ce_reg    <= ce_next;
        last_reg  <= last_next;
        if (cmd == CMD_XY_LATCH)
        begin
            byte_reg <= data_byte;
        end
        if (cmd == CMD_FETCH_OUT)
        begin
            px_reg  <= x_q;
            py_reg  <= y_q;
            on_reg  <= flag_q[0];
            idx_reg <= 8'(cur_reg[PtW-1:0]);
        end
        if (cmd == CMD_EMIT)
        begin
            status      <= res_reg;
            point_x     <= (res_reg == ST_POINT) ? px_reg : 16'd0;
            point_y     <= (res_reg == ST_POINT) ? py_reg : 16'd0;
            on_curve    <= (res_reg == ST_POINT) && on_reg;
            contour_end <= (res_reg == ST_POINT) && ce_reg;
            last_point  <= (res_reg == ST_POINT) && last_reg;
            point_index <= (res_reg == ST_POINT) ? idx_reg : 8'd0;
        end
    end

    // Registered reads every cycle: end_mem at fc_reg, the others at the cursor.
    always_ff @(posedge clk)
    begin
        if (flag_we)
        begin
            flag_mem[cur_reg[PtW-1:0]] <= flag_wd;
        end
        if (coord_we && !is_y)
        begin
            x_mem[cur_reg[PtW-1:0]] <= run_next;
        end
        if (coord_we && is_y)
        begin
            y_mem[cur_reg[PtW-1:0]] <= run_next;
        end
        if (end_we)
        begin
            end_mem[end_wa] <= end_wd;
        end
        flag_q <= flag_mem[cur_reg[PtW-1:0]];
        x_q    <= x_mem[cur_reg[PtW-1:0]];
        y_q    <= y_mem[cur_reg[PtW-1:0]];
        end_q  <= end_mem[fc_reg[CtW-1:0]];
    end

endmodule

FILE: rtl/core/glyph_outline_point_decoder_top.sv
// Glyph outline point decoder: takes a simple glyph record one byte word at
// a time, and one word per op, and returns one result word per input word.
// Words are handled one at a time. A header, end-index, instruction or flag
// byte goes through the settle check to the output register; a repeat byte
// first writes each repeated flag in turn. The first byte of a coordinate
// word is latched and processed and then goes out. A byte that completes a
// coordinate also runs the settle loop: a read and a check step for each
// point checked, the one that stops the loop by needing bytes included, and
// an advance step at each x-to-y or final transition, set by the one-port
// flag memory with its registered read. A flag or repeat byte that ends the
// flag list runs the same loop. A point fetch passes a fetch step; a restart
// or a rejected op goes straight to the output. A new word is taken once the
// previous result is in the output register, after any wait for out_ready.
// Depends on gopd_pkg, gopd_ctrl and gopd_dp.
module glyph_outline_point_decoder_top
    import gopd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        op,
    input  logic [7:0]        data_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        status,
    output logic signed [15:0] point_x,
    output logic signed [15:0] point_y,
    output logic              on_curve,
    output logic              contour_end,
    output logic              last_point,
    output logic [7:0]        point_index
);

    cmd_t     cmd;
    dp_stat_t stat;

    gopd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    gopd_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .stat        (stat),
        .status      (status),
        .point_x     (point_x),
        .point_y     (point_y),
        .on_curve    (on_curve),
        .contour_end (contour_end),
        .last_point  (last_point),
        .point_index (point_index)
    );

endmodule
